// ===== rtl/ssi_pkg.sv =====
// Package for the segment crossing block.
// Holds default sizes and the per-item control word that travels down the pipeline.
// No dependencies.
`default_nettype none

package ssi_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Control that moves with each item after it has been classified.
  // When bypass is set the result is fixed: hit as given, fraction one or zero.
  typedef struct packed {
    logic valid;
    logic bypass;
    logic hit;
    logic sat_one;
  } ssi_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ssi_cross.sv =====
// Front end of the segment crossing pipeline: differences, products and cross products.
// Three register stages. Uses ssi_pkg for nothing but shares its conventions.
`default_nettype none

module ssi_cross #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [COORD_BITS-1:0]         a_x_i,
  input  wire logic [COORD_BITS-1:0]         a_y_i,
  input  wire logic [COORD_BITS-1:0]         b_x_i,
  input  wire logic [COORD_BITS-1:0]         b_y_i,
  input  wire logic [COORD_BITS-1:0]         o_x_i,
  input  wire logic [COORD_BITS-1:0]         o_y_i,
  input  wire logic [COORD_BITS-1:0]         p_x_i,
  input  wire logic [COORD_BITS-1:0]         p_y_i,
  output logic                               valid_o,
  output logic signed [2*COORD_BITS+2:0]     c1_o,
  output logic signed [2*COORD_BITS+2:0]     c2_o,
  output logic signed [2*COORD_BITS+2:0]     num_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * COORD_BITS + 2;
  localparam int unsigned XW = 2 * COORD_BITS + 3;

  logic signed [DW-1:0] abx_q, aby_q, aox_q, aoy_q, apx_q, apy_q;
  logic signed [PW-1:0] p_abx_apy_q, p_aby_apx_q, p_abx_aoy_q, p_aby_aox_q;
  logic signed [PW-1:0] p_aox_apy_q, p_aoy_apx_q;
  logic signed [XW-1:0] c1_q, c2_q, num_q;
  logic [2:0]           v_q;

  function automatic logic signed [DW-1:0] diff(input logic [COORD_BITS-1:0] u,
                                                input logic [COORD_BITS-1:0] w);
    logic signed [DW-1:0] su, sw;
    su = $signed({u[COORD_BITS-1], u});
    sw = $signed({w[COORD_BITS-1], w});
    return su - sw;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abx_q <= diff(b_x_i, a_x_i);
      aby_q <= diff(b_y_i, a_y_i);
      aox_q <= diff(o_x_i, a_x_i);
      aoy_q <= diff(o_y_i, a_y_i);
      apx_q <= diff(p_x_i, a_x_i);
      apy_q <= diff(p_y_i, a_y_i);

      p_abx_apy_q <= PW'(abx_q) * PW'(apy_q);
      p_aby_apx_q <= PW'(aby_q) * PW'(apx_q);
      p_abx_aoy_q <= PW'(abx_q) * PW'(aoy_q);
      p_aby_aox_q <= PW'(aby_q) * PW'(aox_q);
      p_aox_apy_q <= PW'(aox_q) * PW'(apy_q);
      p_aoy_apx_q <= PW'(aoy_q) * PW'(apx_q);

      c1_q  <= XW'(p_abx_apy_q) - XW'(p_aby_apx_q);
      c2_q  <= XW'(p_abx_aoy_q) - XW'(p_aby_aox_q);
      num_q <= XW'(p_aox_apy_q) - XW'(p_aoy_apx_q);
    end
  end

  assign valid_o = v_q[2];
  assign c1_o    = c1_q;
  assign c2_o    = c2_q;
  assign num_o   = num_q;

endmodule

`default_nettype wire

// ===== rtl/ssi_classify.sv =====
// Middle of the pipeline: straddle test, divisor, magnitudes and case selection.
// Three register stages. Depends on ssi_pkg for the control word.
`default_nettype none

module ssi_classify #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic signed [2*COORD_BITS+2:0]     c1_i,
  input  wire logic signed [2*COORD_BITS+2:0]     c2_i,
  input  wire logic signed [2*COORD_BITS+2:0]     num_i,
  output ssi_pkg::ssi_ctrl_t                      ctrl_o,
  output logic [2*COORD_BITS+4:0]                 rem_o,
  output logic [2*COORD_BITS+4:0]                 div_o
);

  localparam int unsigned XW = 2 * COORD_BITS + 3;
  localparam int unsigned W  = XW + 2;

  // Stage 4
  logic signed [XW:0]   den_q;
  logic signed [XW-1:0] num_q;
  logic                 straddle_q;
  logic                 v4_q;
  // Stage 5
  logic [XW-1:0]        mn_q;
  logic [XW:0]          md_q;
  logic                 num_zero_q, sign_diff_q, straddle5_q;
  logic                 v5_q;
  // Stage 6
  ssi_pkg::ssi_ctrl_t   ctrl_q, ctrl_d;
  logic [W-1:0]         rem_q, div_q;

  logic straddle_d;

  assign straddle_d = (c1_i != '0) && (c2_i != '0) && (c1_i[XW-1] != c2_i[XW-1]);

  always_comb begin
    ctrl_d         = '0;
    ctrl_d.valid   = v5_q;
    ctrl_d.bypass  = 1'b1;
    if (!straddle5_q) begin
      ctrl_d.sat_one = 1'b1;
    end else if (num_zero_q) begin
      ctrl_d.hit = 1'b1;
    end else if (sign_diff_q) begin
      ctrl_d.hit = 1'b0;
    end else if ({1'b0, mn_q} >= md_q) begin
      // A ratio of one or more saturates; exactly one still counts as a hit.
      ctrl_d.sat_one = 1'b1;
      ctrl_d.hit     = ({1'b0, mn_q} == md_q);
    end else begin
      ctrl_d.bypass = 1'b0;
      ctrl_d.hit    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      ctrl_q <= '0;
    end else if (en_i) begin
      v4_q   <= valid_i;
      v5_q   <= v4_q;
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q       <= (XW + 1)'(c1_i) - (XW + 1)'(c2_i);
      num_q       <= num_i;
      straddle_q  <= straddle_d;

      mn_q        <= num_q[XW-1] ? -num_q : num_q;
      md_q        <= den_q[XW] ? -den_q : den_q;
      num_zero_q  <= (num_q == '0);
      sign_diff_q <= (num_q[XW-1] != den_q[XW]);
      straddle5_q <= straddle_q;

      rem_q       <= W'(mn_q);
      div_q       <= W'(md_q);
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign div_o  = div_q;

endmodule

`default_nettype wire

// ===== rtl/ssi_div_stage.sv =====
// One stage of the restoring divider: shift, compare, subtract, one quotient bit.
// Depends on ssi_pkg for the control word.
`default_nettype none

module ssi_div_stage #(
  parameter int unsigned W         = 37,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire ssi_pkg::ssi_ctrl_t    ctrl_i,
  input  wire logic [W-1:0]          rem_i,
  input  wire logic [W-1:0]          div_i,
  input  wire logic [FRAC_BITS-1:0]  quo_i,
  output ssi_pkg::ssi_ctrl_t         ctrl_o,
  output logic [W-1:0]               rem_o,
  output logic [W-1:0]               div_o,
  output logic [FRAC_BITS-1:0]       quo_o
);

  ssi_pkg::ssi_ctrl_t    ctrl_q;
  logic [W-1:0]          rem_q, div_q, rem_sh;
  logic [FRAC_BITS-1:0]  quo_q;
  logic                  ge;

  // The remainder stays below the divisor, so the shifted value fits in W bits.
  assign rem_sh = {rem_i[W-2:0], 1'b0};
  assign ge     = (rem_sh >= div_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge ? (rem_sh - div_i) : rem_sh;
      div_q <= div_i;
      quo_q <= {quo_i[FRAC_BITS-2:0], ge};
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign div_o  = div_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/segment_segment_intersection.sv =====
// Segment crossing parameter, computed by a pipeline of cross, classify and divider
// stages; one item is accepted every cycle while results are taken.
// Depth is set by the divider, which forms one quotient bit per pipeline stage.
// The whole pipeline advances together and holds when the output register is full
// and not taken. Reset (rst_ni, asynchronous, active low) clears all valid bits;
// data registers are not reset.
`default_nettype none

module segment_segment_intersection #(
  parameter int unsigned COORD_BITS = ssi_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = ssi_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_W      = ((8 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((FRAC_BITS + 2 + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // a_x, a_y, b_x, b_y, o_x, o_y, p_x, p_y, zero pad
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // hit, fraction, zero pad
  output logic [OUT_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned XW = 2 * COORD_BITS + 3;
  localparam int unsigned W  = XW + 2;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic                          en;
  logic                          x_valid;
  logic signed [XW-1:0]          c1, c2, num;

  ssi_pkg::ssi_ctrl_t            ctrl [FRAC_BITS+1];
  logic [W-1:0]                  rem  [FRAC_BITS+1];
  logic [W-1:0]                  dvs  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]          quo  [FRAC_BITS+1];

  logic                          out_valid_q;
  logic                          hit_q;
  logic [FRAC_BITS:0]            frac_q;
  logic                          hit_d;
  logic [FRAC_BITS:0]            frac_d;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  ssi_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .a_x_i   (s_axis_tdata_i[0*COORD_BITS +: COORD_BITS]),
    .a_y_i   (s_axis_tdata_i[1*COORD_BITS +: COORD_BITS]),
    .b_x_i   (s_axis_tdata_i[2*COORD_BITS +: COORD_BITS]),
    .b_y_i   (s_axis_tdata_i[3*COORD_BITS +: COORD_BITS]),
    .o_x_i   (s_axis_tdata_i[4*COORD_BITS +: COORD_BITS]),
    .o_y_i   (s_axis_tdata_i[5*COORD_BITS +: COORD_BITS]),
    .p_x_i   (s_axis_tdata_i[6*COORD_BITS +: COORD_BITS]),
    .p_y_i   (s_axis_tdata_i[7*COORD_BITS +: COORD_BITS]),
    .valid_o (x_valid),
    .c1_o    (c1),
    .c2_o    (c2),
    .num_o   (num)
  );

  ssi_classify #(
    .COORD_BITS (COORD_BITS)
  ) u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (x_valid),
    .c1_i    (c1),
    .c2_i    (c2),
    .num_i   (num),
    .ctrl_o  (ctrl[0]),
    .rem_o   (rem[0]),
    .div_o   (dvs[0])
  );

  assign quo[0] = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    ssi_div_stage #(
      .W         (W),
      .FRAC_BITS (FRAC_BITS)
    ) u_div_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl[i]),
      .rem_i  (rem[i]),
      .div_i  (dvs[i]),
      .quo_i  (quo[i]),
      .ctrl_o (ctrl[i+1]),
      .rem_o  (rem[i+1]),
      .div_o  (dvs[i+1]),
      .quo_o  (quo[i+1])
    );
  end

  always_comb begin
    if (ctrl[FRAC_BITS].bypass) begin
      hit_d  = ctrl[FRAC_BITS].hit;
      frac_d = ctrl[FRAC_BITS].sat_one ? ONE : '0;
    end else begin
      hit_d  = 1'b1;
      frac_d = {1'b0, quo[FRAC_BITS]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctrl[FRAC_BITS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      frac_q <= frac_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({frac_q, hit_q});

  // A miss only comes from a fixed case, so its fraction is zero or one.
  a_miss_fixed_frac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !hit_q) |-> (frac_q == '0 || frac_q == ONE))
    else $error("miss with a fraction other than zero or one");

  a_frac_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (frac_q <= ONE))
    else $error("fraction above one");

  // A blocked result must hold the whole pipeline, input side included.
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while the output is blocked");

  a_quotient_only_on_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl[FRAC_BITS].valid && !ctrl[FRAC_BITS].bypass && en) |=> (out_valid_q && hit_q))
    else $error("divided item did not leave as a hit");

endmodule

`default_nettype wire
